[hdl/ils_pkg.sv]
// Package for the integer literal scanner: radix and phase codes,
// character constants and the hex digit decoder.
// Depends on nothing; used by integer_literal_scanner and its checker.
`default_nettype none

package ils_pkg;

  // Radix codes as reported on the result.
  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_HEX = 2'd1,
    RADIX_BIN = 2'd2,
    RADIX_OCT = 2'd3
  } radix_e;

  // Scanner phases.
  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_LEAD   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_SKIP   = 2'd3
  } phase_e;

  // Character codes.
  localparam logic [7:0] CH_ZERO   = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE   = 8'h39;  // '9'
  localparam logic [7:0] CH_LO_A   = 8'h61;  // 'a'
  localparam logic [7:0] CH_LO_F   = 8'h66;  // 'f'
  localparam logic [7:0] CH_UP_A   = 8'h41;  // 'A'
  localparam logic [7:0] CH_UP_F   = 8'h46;  // 'F'
  localparam logic [7:0] CH_LO_X   = 8'h78;  // 'x'
  localparam logic [7:0] CH_UP_X   = 8'h58;  // 'X'
  localparam logic [7:0] CH_LO_B   = 8'h62;  // 'b'
  localparam logic [7:0] CH_UP_B   = 8'h42;  // 'B'
  localparam logic [7:0] CH_LO_O   = 8'h6f;  // 'o'
  localparam logic [7:0] CH_UP_O   = 8'h4f;  // 'O'
  localparam logic [7:0] CH_UNDER  = 8'h5f;  // '_'

  // Marker returned by hex_value for a byte that is not a hex digit.
  localparam logic [4:0] NOT_HEX = 5'd16;

  // Value of a hex digit in either case, NOT_HEX for anything else.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      t = c - CH_ZERO;
    end else if (c >= CH_LO_A && c <= CH_LO_F) begin
      t = c - CH_LO_A + 8'd10;
    end else if (c >= CH_UP_A && c <= CH_UP_F) begin
      t = c - CH_UP_A + 8'd10;
    end else begin
      t = {3'b000, NOT_HEX};
    end
    return t[4:0];
  endfunction

endpackage

`default_nettype wire

[hdl/integer_literal_scanner.sv]
// Integer literal scanner: one source byte per request, one result per literal.
// The result is registered in the output stage when its terminator byte is taken.
// Throughput: one byte per cycle while in_stall_o is low; the accumulator step (shift
// or times ten plus add) is the combinational loop that sets the rate. A two-entry output
// stage lets the input keep running while a result waits. Reset clears the scanner to
// idle and empties the output. Depends on ils_pkg.
`default_nettype none

module integer_literal_scanner
  import ils_pkg::*;
#(
  parameter int VALUE_BITS = 64,
  parameter int COUNT_MAX  = 255
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Byte channel.
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [7:0]            char_in_i,
  // Result channel.
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [VALUE_BITS-1:0]      value_o,
  output logic [1:0]                 radix_kind_o,
  output logic                       bad_digit_o,
  output logic                       overflowed_o,
  output logic                       no_digits_o,
  output logic [7:0]                 chars_used_o
);

  localparam int CW = $clog2(COUNT_MAX + 1);
  localparam int WW = VALUE_BITS + 4;

  // Scanner state.
  phase_e                phase_q, phase_d;
  logic [VALUE_BITS-1:0] acc_q, acc_d;
  radix_e                radix_q, radix_d;
  logic                  bad_q, bad_d;
  logic                  ovf_q, ovf_d;
  logic                  cons_q, cons_d;
  logic [CW-1:0]         cnt_q, cnt_d;

  // Byte classification and the accumulator step.
  logic [4:0]    hexv;
  logic          is_dec, is_hex, is_us, is_prefix;
  logic [3:0]    digit;
  logic          too_big;
  logic [WW-1:0] acc_w, prod, sum;
  logic          ovf_step;
  logic [CW-1:0] cnt_inc;
  logic          digit_path;
  logic          in_fire;

  always_comb begin
    hexv      = hex_value(char_in_i);
    is_hex    = (hexv != NOT_HEX);
    is_dec    = (char_in_i >= CH_ZERO) && (char_in_i <= CH_NINE);
    is_us     = (char_in_i == CH_UNDER);
    is_prefix = (char_in_i == CH_LO_X) || (char_in_i == CH_UP_X) ||
                (char_in_i == CH_LO_B) || (char_in_i == CH_UP_B) ||
                (char_in_i == CH_LO_O) || (char_in_i == CH_UP_O);
  end

  // Digit value checked against the base, then acc * base + digit with headroom bits.
  always_comb begin
    case (radix_q)
      RADIX_DEC: too_big = (hexv[3:0] >= 4'd10);
      RADIX_HEX: too_big = 1'b0;
      RADIX_BIN: too_big = (hexv[3:0] >= 4'd2);
      RADIX_OCT: too_big = (hexv[3:0] >= 4'd8);
      default:   too_big = 1'b0;
    endcase
    digit = too_big ? 4'd0 : hexv[3:0];
    acc_w = {4'b0000, acc_q};
    case (radix_q)
      RADIX_DEC: prod = (acc_w << 3) + (acc_w << 1);
      RADIX_HEX: prod = acc_w << 4;
      RADIX_BIN: prod = acc_w << 1;
      RADIX_OCT: prod = acc_w << 3;
      default:   prod = acc_w;
    endcase
    sum      = prod + {{(WW-4){1'b0}}, digit};
    ovf_step = |sum[WW-1:VALUE_BITS];
    cnt_inc  = (cnt_q < CW'(COUNT_MAX)) ? cnt_q + CW'(1) : cnt_q;
  end

  // Bytes that take the digit route: a non-zero first byte, a non-prefix after
  // the leading zero, and everything in the digit phase.
  assign digit_path = ((phase_q == PH_IDLE) && (char_in_i != CH_ZERO)) ||
                      ((phase_q == PH_LEAD) && !is_prefix) ||
                      (phase_q == PH_DIGITS);

  // Output decode: does this byte end the literal, and with which fields.
  logic                  emit;
  logic                  emit_ovf;
  logic [VALUE_BITS-1:0] res_value;
  logic [1:0]            res_radix;
  logic                  res_bad, res_ovf, res_nodig;
  logic [7:0]            res_chars;
  logic [CW+7:0]         cnt_ext;

  always_comb begin
    // A letter digit that overflows ends the literal with the value zeroed.
    emit_ovf  = digit_path && is_hex && ovf_step && !is_dec;
    emit      = (digit_path && !is_us && !is_hex) || emit_ovf ||
                ((phase_q == PH_SKIP) && !is_dec);
    res_value = emit_ovf ? '0 : acc_q;
    res_radix = radix_q;
    res_bad   = bad_q | (emit_ovf & too_big);
    res_ovf   = ovf_q | emit_ovf;
    res_nodig = !cons_q;
    cnt_ext   = {8'd0, cnt_q};
    res_chars = cnt_ext[7:0];
  end

  // Next-state logic of the scanner.
  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    radix_d = radix_q;
    bad_d   = bad_q;
    ovf_d   = ovf_q;
    cons_d  = cons_q;
    cnt_d   = cnt_q;
    if (emit) begin
      phase_d = PH_IDLE;
      acc_d   = '0;
      radix_d = RADIX_DEC;
      bad_d   = 1'b0;
      ovf_d   = 1'b0;
      cons_d  = 1'b0;
      cnt_d   = '0;
    end else begin
      case (phase_q)
        PH_IDLE: begin
          if (char_in_i == CH_ZERO) begin
            cnt_d   = cnt_inc;
            cons_d  = 1'b1;
            phase_d = PH_LEAD;
          end
        end
        PH_LEAD: begin
          if (is_prefix) begin
            if ((char_in_i == CH_LO_X) || (char_in_i == CH_UP_X)) begin
              radix_d = RADIX_HEX;
            end else if ((char_in_i == CH_LO_B) || (char_in_i == CH_UP_B)) begin
              radix_d = RADIX_BIN;
            end else begin
              radix_d = RADIX_OCT;
            end
            cnt_d   = cnt_inc;
            cons_d  = 1'b0;
            phase_d = PH_DIGITS;
          end
        end
        PH_SKIP: begin
          cnt_d = cnt_inc;
        end
        default: begin
        end
      endcase
      // Digit route that does not end the literal.
      if (digit_path) begin
        phase_d = PH_DIGITS;
        cnt_d   = cnt_inc;
        cons_d  = 1'b1;
        if (!is_us) begin
          bad_d = bad_q | too_big;
          if (ovf_step) begin
            ovf_d   = 1'b1;
            acc_d   = '0;
            phase_d = PH_SKIP;
          end else begin
            acc_d = sum[VALUE_BITS-1:0];
          end
        end
      end
    end
  end

  assign in_fire = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      acc_q   <= '0;
      radix_q <= RADIX_DEC;
      bad_q   <= 1'b0;
      ovf_q   <= 1'b0;
      cons_q  <= 1'b0;
      cnt_q   <= '0;
    end else if (in_fire) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      radix_q <= radix_d;
      bad_q   <= bad_d;
      ovf_q   <= ovf_d;
      cons_q  <= cons_d;
      cnt_q   <= cnt_d;
    end
  end

  // Output register with one skid entry behind it.
  logic                  out_v_q, skid_v_q;
  logic [VALUE_BITS-1:0] out_value_q, skid_value_q;
  logic [1:0]            out_radix_q, skid_radix_q;
  logic                  out_bad_q, skid_bad_q;
  logic                  out_ovf_q, skid_ovf_q;
  logic                  out_nodig_q, skid_nodig_q;
  logic [7:0]            out_chars_q, skid_chars_q;
  logic                  new_res, out_pop;
  logic                  load_out_new, load_out_skid, load_skid;

  assign new_res       = in_fire && emit;
  assign out_pop       = out_v_q && !out_stall_i;
  assign load_out_skid = out_pop && skid_v_q;
  assign load_out_new  = new_res && (!out_v_q || (out_pop && !skid_v_q));
  assign load_skid     = new_res && !load_out_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= load_out_new || load_out_skid || (out_v_q && !out_pop);
      skid_v_q <= load_skid || (skid_v_q && !load_out_skid);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out_skid) begin
      out_value_q <= skid_value_q;
      out_radix_q <= skid_radix_q;
      out_bad_q   <= skid_bad_q;
      out_ovf_q   <= skid_ovf_q;
      out_nodig_q <= skid_nodig_q;
      out_chars_q <= skid_chars_q;
    end else if (load_out_new) begin
      out_value_q <= res_value;
      out_radix_q <= res_radix;
      out_bad_q   <= res_bad;
      out_ovf_q   <= res_ovf;
      out_nodig_q <= res_nodig;
      out_chars_q <= res_chars;
    end
    if (load_skid) begin
      skid_value_q <= res_value;
      skid_radix_q <= res_radix;
      skid_bad_q   <= res_bad;
      skid_ovf_q   <= res_ovf;
      skid_nodig_q <= res_nodig;
      skid_chars_q <= res_chars;
    end
  end

  assign in_stall_o   = skid_v_q;
  assign out_valid_o  = out_v_q;
  assign value_o      = out_value_q;
  assign radix_kind_o = out_radix_q;
  assign bad_digit_o  = out_bad_q;
  assign overflowed_o = out_ovf_q;
  assign no_digits_o  = out_nodig_q;
  assign chars_used_o = out_chars_q;

endmodule

`default_nettype wire

[hdl/ils_checker.sv]
// Port-level checker for the integer literal scanner, bound into integer_literal_scanner.
// Depends on ils_pkg and integer_literal_scanner.
`default_nettype none

module ils_checker
  import ils_pkg::*;
#(
  parameter int VALUE_BITS = 64
) (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid_i,
  input wire logic                  in_stall_o,
  input wire logic                  out_valid_o,
  input wire logic                  out_stall_i,
  input wire logic [VALUE_BITS-1:0] value_o,
  input wire logic                  bad_digit_o,
  input wire logic                  overflowed_o,
  input wire logic                  no_digits_o,
  input wire logic [7:0]            chars_used_o
);

  // A stalled result stays offered with the same value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(value_o) && $stable(chars_used_o))
    else $error("stalled result changed");

  // The input only stalls when a result is already waiting.
  a_stall_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // The skid entry only fills while the output was held and a request came in.
  a_stall_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i && in_valid_i))
    else $error("input stall rose without a held result");

  // An overflowed literal reports a zero value.
  a_ovf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflowed_o |-> value_o == '0)
    else $error("overflowed result with nonzero value");

  // A literal with no digits has neither a value nor an overflow.
  a_nodig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && no_digits_o |-> value_o == '0 && !overflowed_o && !bad_digit_o)
    else $error("empty literal with content");

endmodule

bind integer_literal_scanner ils_checker #(.VALUE_BITS(VALUE_BITS)) u_ils_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .value_o      (value_o),
  .bad_digit_o  (bad_digit_o),
  .overflowed_o (overflowed_o),
  .no_digits_o  (no_digits_o),
  .chars_used_o (chars_used_o)
);

`default_nettype wire
